### hdl/sobel_edge_magnitude_macros.svh
// Assertion macros of the edge filter, used by the control module sem_ctrl.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");
`else
`define SEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sem_pkg.sv
// Types, constants and helper functions of the edge magnitude filter.
package sem_pkg;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_MAX = 255;
  localparam int DIM_W = 11;
  localparam int COEF_W = 63;
  localparam int TAP_W = 7;
  localparam int TAPS = 9;
  localparam int CFG_IDX_W = 2;
  localparam int ROOT_W = 9;
  localparam int SQ_W = 17;
  localparam int SUM_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 2'd3;

  localparam logic [DIM_W-1:0] RST_WIDTH = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic update;
    logic conv;
    logic square;
    logic root_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic started;
    logic root_done;
    logic out_busy;
  } sts_t;

  function automatic logic signed [TAP_W-1:0] tap_of(input logic [COEF_W-1:0] p,
                                                    input int k);
    return $signed(p[TAP_W*k +: TAP_W]);
  endfunction

  function automatic logic [7:0] clamp_pix(input logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s > SUM_W'(PIX_MAX)) begin
      r = 8'(PIX_MAX);
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction
endpackage

### hdl/sobel_edge_magnitude.sv
// Top level of the 3x3 edge magnitude filter over an RGB raster stream.
// An item that gives no result passes the IDLE, READ and CONV states; one that gives a result
// also passes SQ, ROOT (the 9-step bitwise root unit) and EMIT, waiting there on the output register.
// Results lag the input stream by image_width+1 transactions.
// After reset the row stores are cleared address by address with the input stalled.
// Reset is synchronous, active low; configuration returns to 640 x 480 with zero taps.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::COEF_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_magnitude,
  output logic [7:0]                    out_grad_x,
  output logic [7:0]                    out_grad_y,
  output logic                          out_frame_last
);
  import sem_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_action(in_action), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall), .out_magnitude(out_magnitude),
    .out_grad_x(out_grad_x), .out_grad_y(out_grad_y), .out_frame_last(out_frame_last)
  );
endmodule

### hdl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/sem_ctrl.sv
// Sequencing state machine of the edge magnitude filter.
`include "sobel_edge_magnitude_macros.svh"
module sem_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sem_pkg::sts_t sts,
  output sem_pkg::cmd_t cmd
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CONV, S_SQ, S_ROOT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_nxt = S_CONV;
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        state_nxt = sts.started ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SEM_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, !sts.out_busy)
  `SEM_ASSERT_NEXT(a_capture_read, clk, rst_n, cmd.capture, state_r == S_READ)
  `SEM_ASSERT_IMPL(a_clear_stall, clk, rst_n, state_r == S_CLEAR, in_stall)
  `SEM_ASSERT_NEXT(a_root_emit, clk, rst_n, cmd.root_step && sts.root_done,
                   state_r == S_EMIT)
endmodule

### hdl/sem_dp.sv
// Datapath: row stores, grey window, counters, convolutions and root unit.
module sem_dp #(
  parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sem_pkg::cmd_t                 cmd,
  output sem_pkg::sts_t                 sts,
  input  logic                          cfg_valid,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::COEF_W-1:0]    cfg_data,
  input  logic                          in_action,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_magnitude,
  output logic [7:0]                    out_grad_x,
  output logic [7:0]                    out_grad_y,
  output logic                          out_frame_last
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int CWP = $clog2(MAX_WIDTH + 1);
  localparam int RW = DIM_W + 1;

  logic [DIM_W-1:0] width_r, height_r;
  logic [COEF_W-1:0] coef_x_r, coef_y_r;
  logic [CWP-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      coef_x_r <= '0;
      coef_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH: width_r <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_COEF_X: coef_x_r <= cfg_data;
        REG_COEF_Y: coef_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = CWP'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = CWP'(MAX_WIDTH);
    end else begin
      w_eff = CWP'(width_r);
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  logic [CW-1:0] clr_r, in_col_r, out_col_r;
  logic [DIM_W-1:0] in_row_r, out_row_r;
  logic [7:0] grey_r;
  logic started_r;
  logic [7:0] win_r [TAPS];
  logic [7:0] top_rd, mid_rd;
  logic ram_we;
  logic [CW-1:0] ram_waddr;
  logic [7:0] old_wdata, new_wdata;
  logic [9:0] rgb_sum;
  logic [19:0] grey_prod;

  assign rgb_sum = 10'(in_red) + 10'(in_green) + 10'(in_blue);
  assign grey_prod = 20'(rgb_sum) * 20'd683;

  assign ram_we = cmd.clear_step | cmd.update;
  assign ram_waddr = cmd.clear_step ? clr_r : in_col_r;
  assign old_wdata = cmd.clear_step ? 8'd0 : mid_rd;
  assign new_wdata = cmd.clear_step ? 8'd0 : grey_r;

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(old_wdata),
    .re(cmd.capture), .raddr(in_col_r), .rdata(top_rd)
  );
  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(new_wdata),
    .re(cmd.capture), .raddr(in_col_r), .rdata(mid_rd)
  );

  logic in_wrap, out_wrap, last;
  assign in_wrap = (CWP'(in_col_r) + CWP'(1)) >= w_eff;
  assign out_wrap = (CWP'(out_col_r) + CWP'(1)) >= w_eff;
  assign last = (out_row_r >= h_eff - DIM_W'(1)) && (CWP'(out_col_r) >= w_eff - CWP'(1));

  // Padding: a window row or column counts only when it lies inside the image.
  logic [2:0] y_ok, x_ok;
  always_comb begin
    y_ok[0] = (out_row_r != '0) && (RW'(out_row_r) - RW'(1) < RW'(h_eff));
    y_ok[1] = out_row_r < h_eff;
    y_ok[2] = RW'(out_row_r) + RW'(1) < RW'(h_eff);
    x_ok[0] = (out_col_r != '0) && (CWP'(out_col_r) - CWP'(1) < w_eff);
    x_ok[1] = CWP'(out_col_r) < w_eff;
    x_ok[2] = (CWP + 1)'(out_col_r) + (CWP + 1)'(1) < (CWP + 1)'(w_eff);
  end

  logic signed [SUM_W-1:0] sum_x, sum_y;
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (y_ok[k / 3] && x_ok[k % 3]) begin
        sum_x = sum_x + SUM_W'(tap_of(coef_x_r, k)) * SUM_W'($signed({1'b0, win_r[k]}));
        sum_y = sum_y + SUM_W'(tap_of(coef_y_r, k)) * SUM_W'($signed({1'b0, win_r[k]}));
      end
    end
  end

  logic [7:0] gx_r, gy_r;
  logic [SQ_W-1:0] sq_r;
  logic [ROOT_W-1:0] root_r, trial;
  logic [3:0] bit_r;
  logic [2*ROOT_W-1:0] trial_sq;

  assign trial = root_r | (ROOT_W'(1) << bit_r);
  assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      grey_r <= in_action ? 8'd0 : grey_prod[18:11];
    end
    if (cmd.update) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3] <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_rd;
      win_r[5] <= mid_rd;
      win_r[8] <= grey_r;
    end
    if (cmd.conv) begin
      gx_r <= clamp_pix(sum_x);
      gy_r <= clamp_pix(sum_y);
    end
    if (cmd.square) begin
      sq_r <= SQ_W'(16'(gx_r) * 16'(gx_r)) + SQ_W'(16'(gy_r) * 16'(gy_r));
      root_r <= '0;
      bit_r <= 4'(ROOT_W - 1);
    end
    if (cmd.root_step) begin
      if (trial_sq <= (2*ROOT_W)'(sq_r)) root_r <= trial;
      bit_r <= bit_r - 4'd1;
    end
    if (cmd.emit) begin
      out_magnitude <= (root_r > ROOT_W'(PIX_MAX)) ? 8'(PIX_MAX) : root_r[7:0];
      out_grad_x <= gx_r;
      out_grad_y <= gy_r;
      out_frame_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      in_col_r <= '0;
      in_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      started_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + CW'(1);
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.update) begin
        started_r <= (in_row_r >= DIM_W'(2)) ||
                     ((in_row_r == DIM_W'(1)) && (in_col_r != '0));
        if (in_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + DIM_W'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (cmd.emit) begin
        if (last) begin
          in_col_r <= '0;
          in_row_r <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else if (out_wrap) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + DIM_W'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  always_comb begin
    sts.clear_done = (clr_r == CW'(MAX_WIDTH - 1));
    sts.started = started_r;
    sts.root_done = (bit_r == 4'd0);
    sts.out_busy = out_valid & out_stall;
  end
endmodule
